// ===== rtl/nsl_pkg.sv =====
// Shared types, constants and the candidate merge function for the symbol lookup block.
package nsl_pkg;

    localparam int DEF_MAX_SYMBOLS = 1024;
    localparam int NUM_CELLS       = 4;
    localparam int CELL_W          = $clog2(NUM_CELLS);
    // wide enough for a slot of the largest table the block supports
    localparam int SYM_IDX_W       = 16;
    localparam int IDX_OUT_W       = 10;
    localparam int CNT_W           = 11;

    localparam logic       FUNC_LOAD     = 1'b0;
    localparam logic       FUNC_LOOKUP   = 1'b1;
    localparam logic [3:0] KIND_FUNCTION = 4'd2;

    // Table entry as stored: end address is precomputed at load time (33 bits, no wrap).
    typedef struct packed {
        logic        usable;
        logic        sized;
        logic [32:0] end_addr;
        logic [31:0] start;
        logic [31:0] name;
    } sym_entry_t;

    typedef struct packed {
        logic                 have;
        logic [SYM_IDX_W-1:0] idx;
        logic [31:0]          start;
        logic [31:0]          name;
    } cand_t;

    typedef struct packed {
        logic clear;
        logic issue;
    } scan_ctl_t;

    // Greater start wins; equal starts go to the lower slot.
    function automatic cand_t cand_pick(cand_t up, cand_t loc);
        logic take_up;
        take_up = up.have && (!loc.have || (up.start > loc.start) ||
                  ((up.start == loc.start) && (up.idx < loc.idx)));
        return take_up ? up : loc;
    endfunction

endpackage

// ===== rtl/nsl_cell.sv =====
// One search cell: a bank of the symbol table, a local best and one hop of the merge chain.
module nsl_cell
    import nsl_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
    parameter int CELL_ID     = 0,
    localparam int DEPTH      = (MAX_SYMBOLS + NUM_CELLS - 1) / NUM_CELLS,
    localparam int ROW_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LIM_W      = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [ROW_W-1:0]      wr_row,
    input  sym_entry_t            wr_entry,
    input  scan_ctl_t             ctl,
    input  logic [ROW_W-1:0]      rd_row,
    input  logic [LIM_W-1:0]      limit,
    input  logic [31:0]           addr,
    input  cand_t                 chain_in,
    output cand_t                 chain_out
);

    localparam int GI_W  = ROW_W + CELL_W;
    localparam int CMP_W = ((GI_W > LIM_W) ? GI_W : LIM_W) + 1;

    sym_entry_t            mem [0:DEPTH-1];
    sym_entry_t            rd_entry_reg;
    logic [ROW_W-1:0]      rd_row_reg;
    logic                  rd_valid_reg;
    cand_t                 best_reg;
    cand_t                 chain_out_reg;

    logic [GI_W-1:0]       issue_gi;
    logic [GI_W-1:0]       hit_gi;
    logic                  in_range;
    logic                  hit;
    logic                  better;
    cand_t                 hit_cand;

    assign issue_gi = {rd_row, CELL_W'(CELL_ID)};
    assign hit_gi   = {rd_row_reg, CELL_W'(CELL_ID)};
    assign in_range = CMP_W'(issue_gi) < CMP_W'(limit);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_entry;
        end
        if (ctl.issue) begin
            rd_entry_reg <= mem[rd_row];
            rd_row_reg   <= rd_row;
        end
    end

    // unsized entries cover everything from their start upward
    assign hit = rd_entry_reg.usable && (rd_entry_reg.start <= addr) &&
                 (!rd_entry_reg.sized || ({1'b0, addr} < rd_entry_reg.end_addr));
    assign better = !best_reg.have || (rd_entry_reg.start > best_reg.start);

    always_comb begin
        hit_cand.have  = 1'b1;
        hit_cand.idx   = SYM_IDX_W'(hit_gi);
        hit_cand.start = rd_entry_reg.start;
        hit_cand.name  = rd_entry_reg.name;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            best_reg      <= '0;
            chain_out_reg <= '0;
        end else begin
            rd_valid_reg <= ctl.issue && in_range;
            if (ctl.clear) begin
                best_reg <= '0;
            end else if (rd_valid_reg && hit && better) begin
                best_reg <= hit_cand;
            end
            chain_out_reg <= cand_pick(chain_in, best_reg);
        end
    end

    assign chain_out = chain_out_reg;

endmodule

// ===== rtl/nearest_symbol_lookup.sv =====
// Top level of the nearest lower-bound symbol lookup: sequencer, cell row, result register.
//
// Input channel (s_*): valid/ready. s_func = 0 writes one table slot (start, length,
// name offset, kind); a slot at or above MAX_SYMBOLS is dropped. Loads do not stall
// the input and give no result. s_func = 1 looks up s_lookup_address.
// Result channel (m_*): valid/ready, one transaction per lookup.
// cfg_wr_en/cfg_wr_data write symbol_count (clamped to MAX_SYMBOLS); write only when idle.
// The table is split over NUM_CELLS cells by the low slot bits; all cells scan their
// bank in parallel, one row per cycle from a registered memory read, then the best
// candidates ripple down the cell chain one cell per cycle.
// A lookup scans ceil(limit/NUM_CELLS) rows, limit being the clamped symbol_count, then
// drains the cell chain in ST_DRAIN and fills the output register in ST_DONE.
// One lookup is in work at a time; s_ready is low from acceptance of a lookup until
// its result enters the output register.
// The output register holds a result while the receiver stalls; loads and the next
// lookup are still taken, but a finished lookup waits until the register is free.
// Reset (aresetn, synchronous) clears symbol_count and the control state. Table
// contents are not cleared; only written slots may be searched.
module nearest_symbol_lookup
    import nsl_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  logic [9:0]           s_entry_index,
    input  logic [31:0]          s_symbol_start,
    input  logic [31:0]          s_symbol_length,
    input  logic [31:0]          s_symbol_name_offset,
    input  logic [3:0]           s_symbol_kind,
    input  logic [31:0]          s_lookup_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_found,
    output logic [IDX_OUT_W-1:0] m_best_index,
    output logic [31:0]          m_best_name_offset,
    output logic [31:0]          m_offset_within
);

    localparam int DEPTH = (MAX_SYMBOLS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W = $clog2(MAX_SYMBOLS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       symbol_count_reg;
    logic [31:0]            addr_reg;
    logic [LIM_W-1:0]       limit_reg;
    logic [ROW_W:0]         rows_reg;
    logic [ROW_W:0]         row_cnt_reg;
    logic [CELL_W:0]        drain_cnt_reg;
    logic                   m_valid_reg;
    logic                   m_found_reg;
    logic [IDX_OUT_W-1:0]   m_best_index_reg;
    logic [31:0]            m_best_name_offset_reg;
    logic [31:0]            m_offset_within_reg;

    logic [LIM_W-1:0]       limit_next;
    logic [ROW_W:0]         rows_next;
    logic                   s_accept;
    logic                   load_accept;
    logic                   lookup_accept;
    logic                   slot_ok;
    logic [ROW_W-1:0]       wr_row;
    logic [NUM_CELLS-1:0]   wr_en;
    sym_entry_t             wr_entry;
    scan_ctl_t              ctl;
    logic                   out_free;
    cand_t                  chain [0:NUM_CELLS];
    cand_t                  result;

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_accept      = s_valid && s_ready;
    assign load_accept   = s_accept && (s_func == FUNC_LOAD);
    assign lookup_accept = s_accept && (s_func == FUNC_LOOKUP);

    always_comb begin
        if (32'(symbol_count_reg) > 32'(MAX_SYMBOLS)) begin
            limit_next = LIM_W'(MAX_SYMBOLS);
        end else begin
            limit_next = LIM_W'(symbol_count_reg);
        end
        rows_next = (ROW_W + 1)'((32'(limit_next) + NUM_CELLS - 1) >> CELL_W);
    end

    // load path: slot low bits pick the cell, the rest the row
    assign slot_ok = 32'(s_entry_index) < 32'(MAX_SYMBOLS);
    assign wr_row  = ROW_W'(32'(s_entry_index) >> CELL_W);

    always_comb begin
        wr_entry.usable   = (s_symbol_kind == KIND_FUNCTION) && (s_symbol_start != 32'd0) &&
                            (s_symbol_name_offset != 32'd0);
        wr_entry.sized    = (s_symbol_length != 32'd0);
        wr_entry.end_addr = {1'b0, s_symbol_start} + {1'b0, s_symbol_length};
        wr_entry.start    = s_symbol_start;
        wr_entry.name     = s_symbol_name_offset;
        for (int k = 0; k < NUM_CELLS; k++) begin
            wr_en[k] = load_accept && slot_ok &&
                       (s_entry_index[CELL_W-1:0] == CELL_W'(k));
        end
    end

    assign ctl.clear = lookup_accept;
    assign ctl.issue = (state_reg == ST_SCAN) && (row_cnt_reg < rows_reg);

    assign chain[0] = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        nsl_cell #(
            .MAX_SYMBOLS (MAX_SYMBOLS),
            .CELL_ID     (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .wr_en     (wr_en[k]),
            .wr_row    (wr_row),
            .wr_entry  (wr_entry),
            .ctl       (ctl),
            .rd_row    (row_cnt_reg[ROW_W-1:0]),
            .limit     (limit_reg),
            .addr      (addr_reg),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    assign result   = chain[NUM_CELLS];
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            symbol_count_reg <= '0;
            row_cnt_reg      <= '0;
            drain_cnt_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                symbol_count_reg <= cfg_wr_data;
            end
            // in ST_DONE the output register is refilled below instead
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (lookup_accept) begin
                        addr_reg    <= s_lookup_address;
                        limit_reg   <= limit_next;
                        rows_reg    <= rows_next;
                        row_cnt_reg <= '0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (ctl.issue) begin
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                    end else begin
                        drain_cnt_reg <= '0;
                        state_reg     <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // last read lands, then one hop per cell down the chain
                    drain_cnt_reg <= drain_cnt_reg + 1'b1;
                    if (drain_cnt_reg == (CELL_W + 1)'(NUM_CELLS - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_found_reg <= result.have;
                        if (result.have) begin
                            m_best_index_reg       <= IDX_OUT_W'(result.idx);
                            m_best_name_offset_reg <= result.name;
                            m_offset_within_reg    <= addr_reg - result.start;
                        end else begin
                            m_best_index_reg       <= '0;
                            m_best_name_offset_reg <= '0;
                            m_offset_within_reg    <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_found            = m_found_reg;
    assign m_best_index       = m_best_index_reg;
    assign m_best_name_offset = m_best_name_offset_reg;
    assign m_offset_within    = m_offset_within_reg;

endmodule

// ===== rtl/nsl_checker.sv =====
// Port-level assertions for the symbol lookup block, bound to the top level.
module nsl_checker
    import nsl_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_func,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_found,
    input logic [IDX_OUT_W-1:0] m_best_index,
    input logic [31:0]          m_best_name_offset,
    input logic [31:0]          m_offset_within
);

    // a miss reports all-zero fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_best_index == '0) && (m_best_name_offset == '0) &&
                                  (m_offset_within == '0))
        else $error("miss result carries nonzero fields");

    // a hit always names a symbol, unnamed entries are skipped
    a_hit_named: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_best_name_offset != 32'd0))
        else $error("hit result with zero name offset");

    // a lookup transaction blocks the input until its result is registered
    a_lookup_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FUNC_LOOKUP)) |=> !s_ready)
        else $error("input ready right after a lookup transaction");

    // a load transaction never stalls the input
    a_load_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FUNC_LOAD)) |=> s_ready)
        else $error("input stalled after a load transaction");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_found) && $stable(m_best_index) &&
                                  $stable(m_offset_within))
        else $error("stalled result changed");

endmodule

bind nearest_symbol_lookup nsl_checker u_nsl_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .s_func             (s_func),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_found            (m_found),
    .m_best_index       (m_best_index),
    .m_best_name_offset (m_best_name_offset),
    .m_offset_within    (m_offset_within)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for nearest_symbol_lookup: table loads, lookups, count settings.
`timescale 1ns / 100ps

module tb_top;
    import nsl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 31;
    // slots loaded up front; counts never reach past them
    localparam int POP_SLOTS      = 192;

    typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    typedef struct {
        logic                 found;
        logic [IDX_OUT_W-1:0] idx;
        logic [31:0]          name;
        logic [31:0]          offs;
    } lookup_result_t;

    class lookup_scoreboard;
        logic [31:0]    sym_start[DEF_MAX_SYMBOLS];
        logic [31:0]    sym_len[DEF_MAX_SYMBOLS];
        logic [31:0]    sym_name[DEF_MAX_SYMBOLS];
        logic [3:0]     sym_kind[DEF_MAX_SYMBOLS];
        int unsigned    symbol_count;
        int unsigned    errors;
        lookup_result_t pending_lookups[$];

        function new();
            symbol_count = 0;
            errors = 0;
        endfunction

        function int unsigned search_limit();
            return (symbol_count > DEF_MAX_SYMBOLS) ? DEF_MAX_SYMBOLS : symbol_count;
        endfunction

        function lookup_result_t resolve_address(logic [31:0] addr);
            lookup_result_t res;
            logic [32:0]    sym_end;
            int unsigned    best;
            res = '{1'b0, '0, '0, '0};
            best = 0;
            for (int unsigned i = 0; i < search_limit(); i++) begin
                sym_end = {1'b0, sym_start[i]} + {1'b0, sym_len[i]};
                if (sym_kind[i] != KIND_FUNCTION) continue;
                if (sym_start[i] == 0 || sym_name[i] == 0) continue;
                if (sym_start[i] > addr) continue;
                if (sym_len[i] != 0 && {1'b0, addr} >= sym_end) continue;
                if (!res.found || sym_start[i] > sym_start[best]) begin
                    best = i;
                    res.found = 1'b1;
                end
            end
            if (res.found) begin
                res.idx  = best[IDX_OUT_W-1:0];
                res.name = sym_name[best];
                res.offs = addr - sym_start[best];
            end
            return res;
        endfunction

        function void note_transaction(logic func, logic [9:0] slot, logic [31:0] start,
                                       logic [31:0] len, logic [31:0] name,
                                       logic [3:0] kind, logic [31:0] addr);
            if (func == FUNC_LOAD) begin
                sym_start[slot] = start;
                sym_len[slot]   = len;
                sym_name[slot]  = name;
                sym_kind[slot]  = kind;
            end else begin
                pending_lookups.push_back(resolve_address(addr));
            end
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            end
        endfunction

        function void check_lookup(logic found, logic [IDX_OUT_W-1:0] idx,
                                   logic [31:0] name, logic [31:0] offs);
            lookup_result_t want;
            if (pending_lookups.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending, expected none, actual %b/%0d/%h/%h",
                         $time, found, idx, name, offs);
                return;
            end
            want = pending_lookups.pop_front();
            compare_field("found", 32'(want.found), 32'(found));
            compare_field("best_index", 32'(want.idx), 32'(idx));
            compare_field("best_name_offset", want.name, name);
            compare_field("offset_within", want.offs, offs);
        endfunction

        // Pick an address near a searched symbol so most lookups land on its edges.
        function logic [31:0] near_address();
            int unsigned i;
            logic [31:0] s;
            logic [31:0] l;
            if (search_limit() == 0) return $urandom;
            i = $urandom_range(search_limit() - 1, 0);
            s = sym_start[i];
            l = sym_len[i];
            case ($urandom_range(5, 0))
                0: return s;
                1: return s - 1;
                2: return s + l - 1;
                3: return s + l;
                4: return s + $urandom_range(32'h3ff, 0);
                default: return $urandom;
            endcase
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CNT_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_func;
    logic [9:0]           s_entry_index;
    logic [31:0]          s_symbol_start;
    logic [31:0]          s_symbol_length;
    logic [31:0]          s_symbol_name_offset;
    logic [3:0]           s_symbol_kind;
    logic [31:0]          s_lookup_address;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_found;
    logic [IDX_OUT_W-1:0] m_best_index;
    logic [31:0]          m_best_name_offset;
    logic [31:0]          m_offset_within;

    lookup_scoreboard sb = new();
    int unsigned send_pct = 0;
    int unsigned recv_pct = 0;
    int unsigned quiet_cycles = 0;
    logic [31:0] prev_start = 32'h0040_0000;

    nearest_symbol_lookup dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_func               (s_func),
        .s_entry_index        (s_entry_index),
        .s_symbol_start       (s_symbol_start),
        .s_symbol_length      (s_symbol_length),
        .s_symbol_name_offset (s_symbol_name_offset),
        .s_symbol_kind        (s_symbol_kind),
        .s_lookup_address     (s_lookup_address),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_found              (m_found),
        .m_best_index         (m_best_index),
        .m_best_name_offset   (m_best_name_offset),
        .m_offset_within      (m_offset_within)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99, 0) >= recv_pct);
    end

    // Result monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_lookup(m_found, m_best_index, m_best_name_offset, m_offset_within);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: watchdog expired", $time);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    function automatic void set_pace(pace_t pace);
        case (pace)
            PACE_FULL:       begin send_pct = 0;  recv_pct = 0;  end
            PACE_SEND_IDLE:  begin send_pct = 75; recv_pct = 0;  end
            PACE_RECV_STALL: begin send_pct = 0;  recv_pct = 75; end
            default:         begin send_pct = 9;  recv_pct = 9;  end
        endcase
    endfunction

    task automatic send_item(input logic func, input logic [9:0] slot,
                             input logic [31:0] start, input logic [31:0] len,
                             input logic [31:0] name, input logic [3:0] kind,
                             input logic [31:0] addr);
        int unsigned gap;
        gap = 0;
        while (gap < 200 && $urandom_range(99, 0) < send_pct) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid              = 1'b1;
        s_func               = func;
        s_entry_index        = slot;
        s_symbol_start       = start;
        s_symbol_length      = len;
        s_symbol_name_offset = name;
        s_symbol_kind        = kind;
        s_lookup_address     = addr;
        do @(posedge aclk); while (!s_ready);
        sb.note_transaction(func, slot, start, len, name, kind, addr);
    endtask

    task automatic send_load(input logic [9:0] slot, input logic [31:0] start,
                             input logic [31:0] len, input logic [31:0] name,
                             input logic [3:0] kind);
        send_item(FUNC_LOAD, slot, start, len, name, kind, $urandom);
    endtask

    task automatic send_lookup(input logic [31:0] addr);
        send_item(FUNC_LOOKUP, 10'($urandom), $urandom, $urandom, $urandom, 4'($urandom), addr);
    endtask

    // Clustered starts, shared starts for ties, sizes that reach past the 32-bit top.
    task automatic load_random(input logic [9:0] slot);
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] name;
        logic [3:0]  kind;
        case ($urandom_range(7, 0))
            0, 1, 2: start = 32'h0040_0000 + $urandom_range(32'hffff, 0);
            3:       start = prev_start;
            4:       start = $urandom_range(255, 0);
            default: start = $urandom;
        endcase
        prev_start = start;
        case ($urandom_range(3, 0))
            0:       len = '0;
            1:       len = $urandom_range(32'h800, 1);
            2:       len = $urandom;
            default: len = 32'hffff_ffff - $urandom_range(15, 0);
        endcase
        name = ($urandom_range(7, 0) == 0) ? 32'h0 : $urandom;
        kind = ($urandom_range(3, 0) != 0) ? KIND_FUNCTION : 4'($urandom);
        send_load(slot, start, len, name, kind);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        sb.symbol_count = value;
    endtask

    initial begin
        int unsigned      lim;
        logic [CNT_W-1:0] new_count;
        logic [9:0]       slot;

        aresetn              = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        s_valid              = 1'b0;
        s_func               = FUNC_LOAD;
        s_entry_index        = '0;
        s_symbol_start       = '0;
        s_symbol_length      = '0;
        s_symbol_name_offset = '0;
        s_symbol_kind        = '0;
        s_lookup_address     = '0;
        m_ready              = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty table first, then edge cases on a small table
        set_pace(PACE_FULL);
        send_lookup(32'h0000_1000);
        send_load(10'd0, 32'h0000_1000, 32'h100, 32'h11, KIND_FUNCTION);
        send_load(10'd1, 32'h0000_1000, 32'h0, 32'h5, 4'hf);          // not a function
        send_load(10'd2, 32'h0, 32'h0, 32'h7, KIND_FUNCTION);         // zero start
        send_load(10'd3, 32'h0000_2000, 32'h0, 32'h0, KIND_FUNCTION); // unnamed
        send_load(10'd4, 32'h0000_1000, 32'h100, 32'h44, KIND_FUNCTION); // tie with slot 0
        send_load(10'd5, 32'hffff_ff00, 32'hffff_ffff, 32'hffff_ffff, KIND_FUNCTION);
        send_load(10'd6, 32'h0000_3000, 32'h0, 32'h66, KIND_FUNCTION); // unknown size
        send_load(10'd7, 32'h0000_1080, 32'h10, 32'h77, KIND_FUNCTION);
        wait_drained();
        write_count(CNT_W'(8));
        send_lookup(32'h0);
        send_lookup(32'h0000_0fff);
        send_lookup(32'h0000_1000);
        send_lookup(32'h0000_1085);
        send_lookup(32'h0000_1090);
        send_lookup(32'h0000_1100);
        send_lookup(32'h0000_2500);
        send_lookup(32'h0000_3000);
        send_lookup(32'h7fff_ffff);
        send_lookup(32'hffff_ffff);
        wait_drained();

        // Populate the low slots so any count up to POP_SLOTS can be searched
        for (int i = 0; i < POP_SLOTS; i++) load_random(10'(i));

        for (int phase = 0; phase < 12; phase++) begin
            wait_drained();
            set_pace(pace_t'(phase % 4));
            case (phase)
                3:       new_count = CNT_W'(POP_SLOTS);
                6:       new_count = CNT_W'(POP_SLOTS - 1);
                9:       new_count = '0;
                11:      new_count = CNT_W'($urandom_range(POP_SLOTS - 1, 41));
                default: new_count = CNT_W'($urandom_range(40, 1));
            endcase
            write_count(new_count);
            lim = sb.search_limit();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 5 && n == PHASE_ITEMS / 2) wait_drained();
                if ($urandom_range(99, 0) < 35) begin
                    if (lim > 0 && $urandom_range(1, 0) == 0)
                        slot = 10'($urandom_range(lim - 1, 0));
                    else
                        slot = 10'($urandom);
                    load_random(slot);
                end else begin
                    send_lookup(sb.near_address());
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nsl_pkg.sv
rtl/nsl_cell.sv
rtl/nearest_symbol_lookup.sv
rtl/nsl_checker.sv
bench/tb_top.sv
